FILE: rtl/dfc_pkg.sv
`default_nettype none

package dfc_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 150;

	localparam logic [7:0] START_MARK = 8'h2A;
	localparam logic [7:0] END_MARK   = 8'h23;
	localparam logic [7:0] POS_LIMIT  = 8'hFF;

	typedef enum logic [2:0] {
		V_ACCEPT    = 3'd0,
		V_BAD_START = 3'd1,
		V_BAD_END   = 3'd2,
		V_BAD_SUM   = 3'd3,
		V_WRONG_DST = 3'd4,
		V_TOO_LONG  = 3'd5
	} verdict_t;

	typedef enum logic [2:0] {
		K_START,
		K_DEST,
		K_SRC,
		K_LEN,
		K_PAYLOAD,
		K_CHECK,
		K_END,
		K_IGNORE
	} byte_kind_t;

	typedef struct packed {
		byte_kind_t  kind;
		logic [7:0]  data;
		logic        last;
		logic        short_hdr;
	} entry_t;

endpackage

`default_nettype wire

FILE: rtl/dfc_rx_if.sv
`default_nettype none

interface dfc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_packet;

	modport source (output valid, output rx_byte, output end_of_packet, input ready);
	modport sink (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

`default_nettype wire

FILE: rtl/dfc_res_if.sv
`default_nettype none

interface dfc_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;
	logic [7:0] dest_address;
	logic [7:0] source_address;
	logic [7:0] payload_length;
	logic [7:0] computed_sum;

	modport source (
		output valid, output verdict, output dest_address, output source_address,
		output payload_length, output computed_sum, input ready
	);
	modport sink (
		input valid, input verdict, input dest_address, input source_address,
		input payload_length, input computed_sum, output ready
	);
endinterface

`default_nettype wire

FILE: rtl/dfc_front.sv
`default_nettype none

module dfc_front (
	input  wire            clk,
	input  wire            arst_n,
	dfc_rx_if.sink         rx,
	input  wire            full,
	output logic           push,
	output dfc_pkg::entry_t entry
);
	import dfc_pkg::*;

	logic [7:0] pos_q;
	logic [7:0] len_q;
	logic [7:0] pos_next;
	logic [8:0] pay_end;
	logic [8:0] pos_ext;
	byte_kind_t kind;

	assign rx.ready = !full;
	assign push     = rx.valid && !full;

	assign pos_ext  = {1'b0, pos_q};
	assign pay_end  = {1'b0, len_q} + 9'd4;
	assign pos_next = (pos_q == POS_LIMIT) ? POS_LIMIT : pos_q + 8'd1;

	always_comb begin
		if (pos_q == POS_LIMIT) begin
			kind = K_IGNORE;
		end else if (pos_q == 8'd0) begin
			kind = K_START;
		end else if (pos_q == 8'd1) begin
			kind = K_DEST;
		end else if (pos_q == 8'd2) begin
			kind = K_SRC;
		end else if (pos_q == 8'd3) begin
			kind = K_LEN;
		end else if (pos_ext < pay_end) begin
			kind = K_PAYLOAD;
		end else if (pos_ext == pay_end) begin
			kind = K_CHECK;
		end else if (pos_ext == pay_end + 9'd1) begin
			kind = K_END;
		end else begin
			kind = K_IGNORE;
		end
	end

	always_comb begin
		entry.kind      = kind;
		entry.data      = rx.rx_byte;
		entry.last      = rx.end_of_packet;
		entry.short_hdr = (pos_next < 8'd4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
		end else if (push) begin
			if (rx.end_of_packet) begin
				pos_q <= '0;
				len_q <= '0;
			end else begin
				pos_q <= pos_next;
				if (kind == K_LEN) begin
					len_q <= rx.rx_byte;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dfc_queue.sv
`default_nettype none

module dfc_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  dfc_pkg::entry_t push_entry,
	output logic            full,
	input  wire             pop,
	output logic            head_valid,
	output dfc_pkg::entry_t head
);
	import dfc_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dfc_back.sv
`default_nettype none

module dfc_back (
	input  wire             clk,
	input  wire             arst_n,
	input  wire  [7:0]      own_address,
	input  wire             head_valid,
	input  dfc_pkg::entry_t head,
	output logic            pop,
	dfc_res_if.source       res
);
	import dfc_pkg::*;

	logic [7:0] dest_q, src_q, len_q, sum_q;
	logic       start_ok_q, end_ok_q, sum_ok_q;
	logic [7:0] dest_n, src_n, len_n, sum_n;
	logic       start_ok_n, end_ok_n, sum_ok_n;
	logic       out_valid_q;
	verdict_t   verdict_q, verdict_n;
	logic [7:0] out_dest_q, out_src_q, out_len_q, out_sum_q;
	logic [8:0] frame_len;

	assign pop = head_valid && (!head.last || !out_valid_q || res.ready);

	always_comb begin
		dest_n     = dest_q;
		src_n      = src_q;
		len_n      = len_q;
		sum_n      = sum_q;
		start_ok_n = start_ok_q;
		end_ok_n   = end_ok_q;
		sum_ok_n   = sum_ok_q;
		case (head.kind)
			K_START:   start_ok_n = (head.data == START_MARK);
			K_DEST:    dest_n     = head.data;
			K_SRC:     src_n      = head.data;
			K_LEN:     len_n      = head.data;
			K_PAYLOAD: sum_n      = sum_q + head.data;
			K_CHECK:   sum_ok_n   = (head.data == sum_q);
			K_END:     end_ok_n   = (head.data == END_MARK);
			default: ;
		endcase
	end

	assign frame_len = {1'b0, len_n} + 9'd6;

	always_comb begin
		if (!start_ok_n) begin
			verdict_n = V_BAD_START;
		end else if (head.short_hdr) begin
			verdict_n = V_BAD_END;
		end else if (frame_len > 9'(MAX_FRAME_BYTES)) begin
			verdict_n = V_TOO_LONG;
		end else if (!end_ok_n) begin
			verdict_n = V_BAD_END;
		end else if (!sum_ok_n) begin
			verdict_n = V_BAD_SUM;
		end else if (dest_n != own_address) begin
			verdict_n = V_WRONG_DST;
		end else begin
			verdict_n = V_ACCEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_q     <= '0;
			src_q      <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			start_ok_q <= 1'b0;
			end_ok_q   <= 1'b0;
			sum_ok_q   <= 1'b0;
		end else if (pop) begin
			if (head.last) begin
				dest_q     <= '0;
				src_q      <= '0;
				len_q      <= '0;
				sum_q      <= '0;
				start_ok_q <= 1'b0;
				end_ok_q   <= 1'b0;
				sum_ok_q   <= 1'b0;
			end else begin
				dest_q     <= dest_n;
				src_q      <= src_n;
				len_q      <= len_n;
				sum_q      <= sum_n;
				start_ok_q <= start_ok_n;
				end_ok_q   <= end_ok_n;
				sum_ok_q   <= sum_ok_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			verdict_q  <= verdict_n;
			out_dest_q <= dest_n;
			out_src_q  <= src_n;
			out_len_q  <= len_n;
			out_sum_q  <= sum_n;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.verdict        = verdict_q;
	assign res.dest_address   = out_dest_q;
	assign res.source_address = out_src_q;
	assign res.payload_length = out_len_q;
	assign res.computed_sum   = out_sum_q;

endmodule

`default_nettype wire

FILE: rtl/delimited_frame_checker.sv
// Checks delimited radio frames that arrive one byte per transfer on rx.
// A frame is '*', destination, source, length N, N payload bytes, a modulo
// 256 sum of the payload and '#'. The transfer that carries end_of_packet
// closes the packet, and one verdict with the captured header fields and the
// payload sum is offered on res; no other byte produces a result.
// The register own_address is loaded from cfg_wr_data at any clock edge with
// cfg_wr_en high, and it should only change while the block is idle.
// A front stage tags each byte with its role in the frame, a two-entry queue
// holds the tagged bytes, and a back stage updates the checks and builds the
// verdict in an output register.
// The block takes one byte per cycle while the queue is not full. The verdict
// is registered when the byte that carries end_of_packet is popped from the
// queue. When res is stalled, bytes of the next packet keep flowing until
// the byte that carries the next end_of_packet reaches the head of the queue;
// then the queue fills and rx.ready drops until the waiting verdict is taken.
// Reset clears the byte position, the per-packet checks, the queue and the
// output valid flag, and own_address returns to zero.
`default_nettype none

module delimited_frame_checker (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       cfg_wr_en,
	input  wire [7:0] cfg_wr_data,
	dfc_rx_if.sink    rx,
	dfc_res_if.source res
);
	import dfc_pkg::*;

	logic [7:0] own_address_q;
	logic       push;
	logic       full;
	logic       pop;
	logic       head_valid;
	entry_t     push_entry;
	entry_t     head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
		end else if (cfg_wr_en) begin
			own_address_q <= cfg_wr_data;
		end
	end

	dfc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.full   (full),
		.push   (push),
		.entry  (push_entry)
	);

	dfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	dfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_address (own_address_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.res         (res)
	);

endmodule

`default_nettype wire

FILE: rtl/dfc_checker.sv
`default_nettype none

module dfc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       res_valid,
	input wire       res_ready,
	input wire [2:0] res_verdict,
	input wire [7:0] res_payload_length
);
	import dfc_pkg::*;

	// A stalled result keeps its verdict.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_verdict))
		else $error("result changed while stalled");

	a_reset_clear: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// An accepted frame must fit the frame limit.
	a_accept_fits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_verdict == V_ACCEPT)
		|-> ({1'b0, res_payload_length} + 9'd6 <= 9'(MAX_FRAME_BYTES)))
		else $error("accepted frame exceeds the length limit");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_verdict <= V_TOO_LONG))
		else $error("verdict code out of range");

endmodule

bind delimited_frame_checker dfc_checker u_dfc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_verdict        (res.verdict),
	.res_payload_length (res.payload_length)
);

`default_nettype wire
